>>> rtl/core/bankers_safety_allocator_macros.svh
// Assertion macros for the banker's safety allocator checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BANKERS_SAFETY_ALLOCATOR_MACROS_SVH
`define BANKERS_SAFETY_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BSA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/bsa_pkg.sv
// Package for the banker's safety allocator: field widths, codes,
// controller states and the controller/datapath command and status structs.
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int CMD_W      = 3;
    localparam int PROC_W     = 3;
    localparam int RES_W      = 2;
    localparam int AMT_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int PCNT_W     = 4;
    localparam int RCNT_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 1'b1;

    localparam logic [PCNT_W-1:0] PCNT_RESET = 4'd5;
    localparam logic [RCNT_W-1:0] RCNT_RESET = 3'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_ALLOC = 3'd0,
        CMD_WR_MAX   = 3'd1,
        CMD_WR_AVAIL = 3'd2,
        CMD_STAGE    = 3'd3,
        CMD_CHECK    = 3'd4,
        CMD_SUBMIT   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SAFE      = 2'd0,
        ST_UNSAFE    = 2'd1,
        ST_OVER_NEED = 2'd2,
        ST_NOT_AVAIL = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SUB_START,
        S_SUB_READ,
        S_SUB_CMP,
        S_SUB_APPLY,
        S_CHK_INIT,
        S_CHK_PROC,
        S_CHK_READ,
        S_CHK_CMP,
        S_CHK_FIN,
        S_CHK_NEXT,
        S_SWEEP_END,
        S_ROLLBACK,
        S_EMIT_SEQ,
        S_ERR_NEED,
        S_ERR_AVAIL,
        S_UNSAFE_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SUB_START,
        OP_SUB_READ,
        OP_SUB_CMP,
        OP_SUB_APPLY,
        OP_CHK_INIT,
        OP_CHK_PROC,
        OP_CHK_READ,
        OP_CHK_CMP,
        OP_CHK_FIN,
        OP_CHK_NEXT,
        OP_SWEEP_END,
        OP_ROLLBACK,
        OP_EMIT_SEQ,
        OP_EMIT_ONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic proc_bad;
        logic r_last;
        logic p_last;
        logic p_done;
        logic need_fail;
        logic over_need;
        logic over_avail;
        logic all_done;
        logic progress;
        logic out_free;
        logic seq_last;
    } dp_stat_t;

endpackage

>>> rtl/core/bsa_if.sv
// Request and result stream interfaces of the banker's safety allocator.
// Depends on bsa_pkg for the field widths.
`timescale 1ns / 1ps

interface bsa_req_if import bsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PROC_W-1:0] process;
    logic [RES_W-1:0]  resource;
    logic [AMT_W-1:0]  amount;

    modport source (output valid, command, process, resource, amount, input ready);
    modport sink   (input valid, command, process, resource, amount, output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PROC_W-1:0]   process_res;
    logic                last;

    modport source (output valid, status, process_res, last, input ready);
    modport sink   (input valid, status, process_res, last, output ready);
endinterface

>>> rtl/core/bsa_ctrl.sv
// Controller state machine of the banker's safety allocator.
// Depends on bsa_pkg; drives the datapath through dp_cmd_t, watches dp_stat_t.
`timescale 1ns / 1ps

module bsa_ctrl import bsa_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] in_command,
    output logic             in_ready,
    output dp_cmd_t          cmd,
    input  dp_stat_t         stat
);

    state_t state_reg;
    state_t state_next;
    logic   sub_mode_reg;
    logic   sub_mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sub_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sub_mode_reg <= sub_mode_next;
        end
    end

    // remember whether the running check belongs to a submit
    always_comb
    begin
        sub_mode_next = sub_mode_reg;
        if (state_reg == S_IDLE && in_valid)
        begin
            sub_mode_next = (cmd_t'(in_command) == CMD_SUBMIT);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_t'(in_command))
                        CMD_CHECK:  state_next = S_CHK_INIT;
                        CMD_SUBMIT: state_next = S_SUB_START;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_SUB_START:
            begin
                state_next = stat.proc_bad ? S_ERR_NEED : S_SUB_READ;
            end
            S_SUB_READ:
            begin
                state_next = S_SUB_CMP;
            end
            S_SUB_CMP:
            begin
                if (stat.over_need)
                    state_next = S_ERR_NEED;
                else if (stat.over_avail)
                    state_next = S_ERR_AVAIL;
                else if (stat.r_last)
                    state_next = S_SUB_APPLY;
                else
                    state_next = S_SUB_READ;
            end
            S_SUB_APPLY:
            begin
                if (stat.r_last)
                    state_next = S_CHK_INIT;
            end
            S_CHK_INIT:
            begin
                state_next = S_CHK_PROC;
            end
            S_CHK_PROC:
            begin
                state_next = stat.p_done ? S_CHK_NEXT : S_CHK_READ;
            end
            S_CHK_READ:
            begin
                state_next = S_CHK_CMP;
            end
            S_CHK_CMP:
            begin
                if (stat.need_fail)
                    state_next = S_CHK_NEXT;
                else if (stat.r_last)
                    state_next = S_CHK_FIN;
                else
                    state_next = S_CHK_READ;
            end
            S_CHK_FIN:
            begin
                state_next = S_CHK_NEXT;
            end
            S_CHK_NEXT:
            begin
                state_next = stat.p_last ? S_SWEEP_END : S_CHK_PROC;
            end
            S_SWEEP_END:
            begin
                if (stat.all_done)
                    state_next = S_EMIT_SEQ;
                else if (!stat.progress)
                    state_next = sub_mode_reg ? S_ROLLBACK : S_UNSAFE_OUT;
                else
                    state_next = S_CHK_PROC;
            end
            S_ROLLBACK:
            begin
                if (stat.r_last)
                    state_next = S_UNSAFE_OUT;
            end
            S_EMIT_SEQ:
            begin
                if (stat.out_free && stat.seq_last)
                    state_next = S_IDLE;
            end
            S_ERR_NEED, S_ERR_AVAIL, S_UNSAFE_OUT:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        cmd.code = ST_SAFE;
        case (state_reg)
            S_IDLE:       in_ready = 1'b1;
            S_SUB_START:  cmd.op = OP_SUB_START;
            S_SUB_READ:   cmd.op = OP_SUB_READ;
            S_SUB_CMP:    cmd.op = OP_SUB_CMP;
            S_SUB_APPLY:  cmd.op = OP_SUB_APPLY;
            S_CHK_INIT:   cmd.op = OP_CHK_INIT;
            S_CHK_PROC:   cmd.op = OP_CHK_PROC;
            S_CHK_READ:   cmd.op = OP_CHK_READ;
            S_CHK_CMP:    cmd.op = OP_CHK_CMP;
            S_CHK_FIN:    cmd.op = OP_CHK_FIN;
            S_CHK_NEXT:   cmd.op = OP_CHK_NEXT;
            S_SWEEP_END:  cmd.op = OP_SWEEP_END;
            S_ROLLBACK:   cmd.op = OP_ROLLBACK;
            S_EMIT_SEQ:   cmd.op = OP_EMIT_SEQ;
            S_ERR_NEED:
            begin
                cmd.op   = OP_EMIT_ONE;
                cmd.code = ST_OVER_NEED;
            end
            S_ERR_AVAIL:
            begin
                cmd.op   = OP_EMIT_ONE;
                cmd.code = ST_NOT_AVAIL;
            end
            S_UNSAFE_OUT:
            begin
                cmd.op   = OP_EMIT_ONE;
                cmd.code = ST_UNSAFE;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

>>> rtl/core/bsa_datapath.sv
// Datapath of the banker's safety allocator: allocation and claim tables,
// vectors, work counters, safe-sequence buffer and result register. Uses bsa_pkg.
`timescale 1ns / 1ps

module bsa_datapath import bsa_pkg::*; #(
    parameter int MAX_PROCS   = 8,
    parameter int MAX_RES     = 4,
    parameter int AMOUNT_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [CMD_W-1:0]      command,
    input  logic [PROC_W-1:0]     process,
    input  logic [RES_W-1:0]      resource,
    input  logic [AMT_W-1:0]      amount,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  rsp_ready,
    output logic                  rsp_valid,
    output logic [STATUS_W-1:0]   rsp_status,
    output logic [PROC_W-1:0]     rsp_process,
    output logic                  rsp_last
);

    localparam int P_W   = $clog2(MAX_PROCS);
    localparam int PN_W  = $clog2(MAX_PROCS + 1);
    localparam int R_W   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int RN_W  = $clog2(MAX_RES + 1);
    localparam int DEPTH = MAX_PROCS * MAX_RES;
    localparam int A_W   = $clog2(DEPTH);
    localparam int W_W   = AMOUNT_BITS + PN_W;

    logic [PCNT_W-1:0]      pcnt_reg;
    logic [RCNT_W-1:0]      rcnt_reg;
    logic [PROC_W-1:0]      proc_reg;

    logic [AMOUNT_BITS-1:0] avail_reg   [MAX_RES];
    logic [AMOUNT_BITS-1:0] staged_reg  [MAX_RES];
    logic [W_W-1:0]         work_reg    [MAX_RES];
    logic [AMOUNT_BITS-1:0] sub_row_reg [MAX_RES];
    logic [AMOUNT_BITS-1:0] chk_row_reg [MAX_RES];

    logic [MAX_PROCS-1:0]   fin_reg;
    logic [P_W-1:0]         order_reg [MAX_PROCS];
    logic [PN_W-1:0]        total_reg;
    logic [P_W-1:0]         p_reg;
    logic [R_W-1:0]         r_reg;
    logic [P_W-1:0]         idx_reg;
    logic                   progress_reg;

    logic [AMOUNT_BITS-1:0] alloc_mem [DEPTH];
    logic [AMOUNT_BITS-1:0] max_mem   [DEPTH];
    logic [DEPTH-1:0]       al_vld_reg;
    logic [DEPTH-1:0]       mx_vld_reg;
    logic [AMOUNT_BITS-1:0] al_rd_reg;
    logic [AMOUNT_BITS-1:0] mx_rd_reg;
    logic                   al_rdv_reg;
    logic                   mx_rdv_reg;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [PROC_W-1:0]      out_proc_reg;
    logic                   out_last_reg;

    logic [PN_W-1:0]        n_act;
    logic [RN_W-1:0]        m_act;
    logic [AMOUNT_BITS-1:0] amt;
    logic                   pok;
    logic                   rok;
    logic [R_W-1:0]         res_idx;
    logic [P_W-1:0]         proc_row;
    logic [P_W-1:0]         row_sel;
    logic [A_W-1:0]         req_addr;
    logic [A_W-1:0]         proc_addr;
    logic [A_W-1:0]         rd_addr;
    logic                   al_we;
    logic [A_W-1:0]         al_waddr;
    logic [AMOUNT_BITS-1:0] al_wdata;
    logic                   mx_we;
    logic [AMOUNT_BITS-1:0] al_val;
    logic [AMOUNT_BITS-1:0] mx_val;
    logic [AMOUNT_BITS-1:0] need;
    logic                   out_free;
    logic                   push;
    logic                   seq_last;
    logic                   r_last;
    logic                   p_last;
    logic [R_W-1:0]         r_adv;

    // saturate the configured counts into their legal ranges
    always_comb
    begin
        if (pcnt_reg == '0)
            n_act = PN_W'(1);
        else if (32'(pcnt_reg) > MAX_PROCS)
            n_act = PN_W'(MAX_PROCS);
        else
            n_act = PN_W'(pcnt_reg);

        if (rcnt_reg == '0)
            m_act = RN_W'(1);
        else if (32'(rcnt_reg) > MAX_RES)
            m_act = RN_W'(MAX_RES);
        else
            m_act = RN_W'(rcnt_reg);
    end

    assign amt       = AMOUNT_BITS'(amount);
    assign pok       = 32'(process) < MAX_PROCS;
    assign rok       = 32'(resource) < MAX_RES;
    assign res_idx   = R_W'(32'(resource));
    assign proc_row  = P_W'(32'(proc_reg));
    assign row_sel   = (cmd.op == OP_SUB_READ) ? proc_row : p_reg;
    assign req_addr  = A_W'(32'(process) * MAX_RES + 32'(resource));
    assign proc_addr = A_W'(32'(proc_row) * MAX_RES + 32'(r_reg));
    assign rd_addr   = A_W'(32'(row_sel) * MAX_RES + 32'(r_reg));

    assign r_last   = 32'(r_reg) == 32'(m_act) - 32'd1;
    assign p_last   = 32'(p_reg) == 32'(n_act) - 32'd1;
    assign seq_last = 32'(idx_reg) == 32'(n_act) - 32'd1;
    assign r_adv    = r_last ? '0 : r_reg + R_W'(1);

    // entries never written read as zero
    assign al_val = al_rdv_reg ? al_rd_reg : '0;
    assign mx_val = mx_rdv_reg ? mx_rd_reg : '0;
    assign need   = (mx_val > al_val) ? mx_val - al_val : '0;

    assign out_free = !out_valid_reg || rsp_ready;
    assign push     = out_free && (cmd.op == OP_EMIT_SEQ || cmd.op == OP_EMIT_ONE);

    assign mx_we = accept && cmd_t'(command) == CMD_WR_MAX && pok && rok;

    always_comb
    begin
        al_we    = 1'b0;
        al_waddr = req_addr;
        al_wdata = amt;
        if (accept && cmd_t'(command) == CMD_WR_ALLOC && pok && rok)
        begin
            al_we = 1'b1;
        end
        else if (cmd.op == OP_SUB_APPLY)
        begin
            al_we    = 1'b1;
            al_waddr = proc_addr;
            al_wdata = sub_row_reg[r_reg] + staged_reg[r_reg];
        end
        else if (cmd.op == OP_ROLLBACK)
        begin
            al_we    = 1'b1;
            al_waddr = proc_addr;
            al_wdata = sub_row_reg[r_reg];
        end
    end

    always_comb
    begin
        stat.proc_bad   = 32'(proc_reg) >= 32'(n_act);
        stat.r_last     = r_last;
        stat.p_last     = p_last;
        stat.p_done     = fin_reg[p_reg];
        stat.need_fail  = W_W'(need) > work_reg[r_reg];
        stat.over_need  = staged_reg[r_reg] > need;
        stat.over_avail = staged_reg[r_reg] > avail_reg[r_reg];
        stat.all_done   = 32'(total_reg) == 32'(n_act);
        stat.progress   = progress_reg;
        stat.out_free   = out_free;
        stat.seq_last   = seq_last;
    end

    // table storage, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (al_we)
            alloc_mem[al_waddr] <= al_wdata;
        if (mx_we)
            max_mem[req_addr] <= amt;
        al_rd_reg <= alloc_mem[rd_addr];
        mx_rd_reg <= max_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            al_vld_reg <= '0;
            mx_vld_reg <= '0;
            al_rdv_reg <= 1'b0;
            mx_rdv_reg <= 1'b0;
        end
        else
        begin
            if (al_we)
                al_vld_reg[al_waddr] <= 1'b1;
            if (mx_we)
                mx_vld_reg[req_addr] <= 1'b1;
            al_rdv_reg <= al_vld_reg[rd_addr];
            mx_rdv_reg <= mx_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg     <= PCNT_RESET;
            rcnt_reg     <= RCNT_RESET;
            proc_reg     <= '0;
            fin_reg      <= '0;
            total_reg    <= '0;
            p_reg        <= '0;
            r_reg        <= '0;
            idx_reg      <= '0;
            progress_reg <= 1'b0;
            for (int i = 0; i < MAX_RES; i++)
            begin
                avail_reg[i]   <= '0;
                staged_reg[i]  <= '0;
                work_reg[i]    <= '0;
                sub_row_reg[i] <= '0;
                chk_row_reg[i] <= '0;
            end
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                order_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PROCESS_COUNT:  pcnt_reg <= cfg_data;
                    CFG_RESOURCE_COUNT: rcnt_reg <= cfg_data[RCNT_W-1:0];
                    default:            pcnt_reg <= pcnt_reg;
                endcase
            end

            if (accept)
            begin
                proc_reg <= process;
                case (cmd_t'(command))
                    CMD_WR_AVAIL:
                    begin
                        if (rok)
                            avail_reg[res_idx] <= amt;
                    end
                    CMD_STAGE:
                    begin
                        if (rok)
                            staged_reg[res_idx] <= amt;
                    end
                    default:
                    begin
                    end
                endcase
            end

            case (cmd.op)
                OP_SUB_START:
                begin
                    r_reg <= '0;
                end
                OP_SUB_CMP:
                begin
                    sub_row_reg[r_reg] <= al_val;
                    r_reg              <= r_adv;
                end
                OP_SUB_APPLY:
                begin
                    // move the request out of available on the first step
                    if (r_reg == '0)
                    begin
                        for (int i = 0; i < MAX_RES; i++)
                        begin
                            if (i < int'(m_act))
                                avail_reg[i] <= avail_reg[i] - staged_reg[i];
                        end
                    end
                    r_reg <= r_adv;
                end
                OP_CHK_INIT:
                begin
                    for (int i = 0; i < MAX_RES; i++)
                    begin
                        work_reg[i] <= (i < int'(m_act)) ? W_W'(avail_reg[i]) : '0;
                    end
                    fin_reg      <= '0;
                    total_reg    <= '0;
                    p_reg        <= '0;
                    r_reg        <= '0;
                    idx_reg      <= '0;
                    progress_reg <= 1'b0;
                end
                OP_CHK_PROC:
                begin
                    r_reg <= '0;
                end
                OP_CHK_CMP:
                begin
                    chk_row_reg[r_reg] <= al_val;
                    r_reg              <= r_adv;
                end
                OP_CHK_FIN:
                begin
                    // release the finished process's allocation into work
                    for (int i = 0; i < MAX_RES; i++)
                    begin
                        if (i < int'(m_act))
                            work_reg[i] <= work_reg[i] + W_W'(chk_row_reg[i]);
                    end
                    fin_reg[p_reg]                 <= 1'b1;
                    order_reg[total_reg[P_W-1:0]] <= p_reg;
                    total_reg                      <= total_reg + PN_W'(1);
                    progress_reg                   <= 1'b1;
                end
                OP_CHK_NEXT:
                begin
                    if (!p_last)
                        p_reg <= p_reg + P_W'(1);
                end
                OP_SWEEP_END:
                begin
                    p_reg        <= '0;
                    r_reg        <= '0;
                    idx_reg      <= '0;
                    progress_reg <= 1'b0;
                end
                OP_ROLLBACK:
                begin
                    if (r_reg == '0)
                    begin
                        for (int i = 0; i < MAX_RES; i++)
                        begin
                            if (i < int'(m_act))
                                avail_reg[i] <= avail_reg[i] + staged_reg[i];
                        end
                    end
                    r_reg <= r_adv;
                end
                OP_EMIT_SEQ:
                begin
                    if (out_free)
                        idx_reg <= idx_reg + P_W'(1);
                end
                default:
                begin
                    r_reg <= r_reg;
                end
            endcase
        end
    end

    // result register: hold while stalled, load when free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (cmd.op == OP_EMIT_SEQ)
            begin
                out_status_reg <= ST_SAFE;
                out_proc_reg   <= PROC_W'(32'(order_reg[idx_reg]));
                out_last_reg   <= seq_last;
            end
            else
            begin
                out_status_reg <= cmd.code;
                out_proc_reg   <= '0;
                out_last_reg   <= 1'b1;
            end
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign rsp_status  = out_status_reg;
    assign rsp_process = out_proc_reg;
    assign rsp_last    = out_last_reg;

endmodule

>>> rtl/core/bankers_safety_allocator.sv
// Top level of the banker's safety allocator: controller plus datapath.
// Depends on bsa_pkg, bsa_if, bsa_ctrl and bsa_datapath.
//
// Channel   Dir  Payload                              Transaction when
// request   in   command, process, resource, amount   valid && ready
// result    out  status, process_res, last            valid && ready
// cfg       in   cfg_index, cfg_data                  cfg_we
//
// Table, vector and staging writes complete in the cycle they are accepted.
// A safety check sweeps the processes, comparing need with work per resource;
// a process that passes releases its allocation into work. Sweeps repeat while
// progress is made, then one result per process gives the safe sequence. One
// registered read port on the allocation and claim tables sets the pace. A
// submit tests and grants the request first, and undoes the grant when unsafe.
// Reset clears every table at once through per-entry valid bits. A stalled
// result holds in the output register; the next request is taken as soon as
// the final result of a transaction is loaded there.
`timescale 1ns / 1ps

module bankers_safety_allocator import bsa_pkg::*; #(
    parameter int MAX_PROCS   = 8,
    parameter int MAX_RES     = 4,
    parameter int AMOUNT_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bsa_req_if.sink               request,
    bsa_rsp_if.source             result
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    logic     in_ready;
    logic     accept;

    assign request.ready = in_ready;
    assign accept        = request.valid && in_ready;

    bsa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (request.valid),
        .in_command (request.command),
        .in_ready   (in_ready),
        .cmd        (dp_cmd),
        .stat       (dp_stat)
    );

    bsa_datapath #(
        .MAX_PROCS   (MAX_PROCS),
        .MAX_RES     (MAX_RES),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (request.command),
        .process     (request.process),
        .resource    (request.resource),
        .amount      (request.amount),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .rsp_ready   (result.ready),
        .rsp_valid   (result.valid),
        .rsp_status  (result.status),
        .rsp_process (result.process_res),
        .rsp_last    (result.last)
    );

endmodule

>>> rtl/core/bsa_checker.sv
// Port-level assertions for the banker's safety allocator, bound to the top.
// Depends on bsa_pkg and bankers_safety_allocator_macros.svh.
`timescale 1ns / 1ps
`include "bankers_safety_allocator_macros.svh"

module bsa_checker import bsa_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic [CMD_W-1:0]    req_command,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [PROC_W-1:0]   rsp_process,
    input logic                rsp_last
);

    logic rsp_stall;
    logic rsp_err;
    logic req_take;
    logic is_write;
    logic is_run;

    assign rsp_stall = rsp_valid && !rsp_ready;
    assign rsp_err   = rsp_valid && rsp_status != ST_SAFE;
    assign req_take  = req_valid && req_ready;
    assign is_write  = req_command == CMD_WR_ALLOC || req_command == CMD_WR_MAX ||
                       req_command == CMD_WR_AVAIL || req_command == CMD_STAGE;
    assign is_run    = req_command == CMD_CHECK || req_command == CMD_SUBMIT;

    // a stalled result must hold
    `BSA_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable({rsp_status, rsp_process, rsp_last}))

    // error and unsafe results stand alone and carry no process
    `BSA_ASSERT_IMPL(a_err_alone, rsp_err, rsp_last && rsp_process == '0)

    // writes and staging never stall the next transaction
    `BSA_ASSERT_NEXT(a_write_quick, req_take && is_write, req_ready)

    // a check or submit keeps the request side busy while it runs
    `BSA_ASSERT_NEXT(a_check_busy, req_take && is_run, !req_ready)

endmodule

bind bankers_safety_allocator bsa_checker u_bsa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (request.valid),
    .req_ready   (request.ready),
    .req_command (request.command),
    .rsp_valid   (result.valid),
    .rsp_ready   (result.ready),
    .rsp_status  (result.status),
    .rsp_process (result.process_res),
    .rsp_last    (result.last)
);
